// File: src/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge once reset is released.
`define AST_HOLDS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must never be seen at a rising edge once reset is released.
`define AST_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: src/vwwp_pkg.sv
// Package with the item types and fixed constants of the word packer.
`timescale 1ns / 1ps

package vwwp_pkg;

    localparam int COEFF_BITS       = 64;
    localparam int CFG_BITS         = 8;
    localparam int MAX_RESULTS      = 4;
    localparam int RESULT_CNT_W     = 3;
    localparam logic [CFG_BITS-1:0] FIELD_BITS_RESET = 8'd64;

    typedef struct packed {
        logic [COEFF_BITS-1:0] coefficient;
        logic                  last_coeff;
    } coef_item_t;

    typedef struct packed {
        logic [COEFF_BITS-1:0] packed_word;
        logic                  last_word;
    } word_item_t;

    typedef struct packed {
        logic [RESULT_CNT_W-1:0] count;
        logic                    ends_stream;
    } pack_ctrl_t;

endpackage

// File: src/variable_width_word_packer_core.sv
// Top level of the variable-width word packer: state, result buffer and output register.
`timescale 1ns / 1ps

//  channel   direction  handshake              payload
//  cfg       in         cfg_write              cfg_data (field width, 8 bits)
//  coef      in         coef_valid/coef_stall  coef_item (coefficient, last_coeff)
//  word      out        word_valid/word_stall  word_item (packed_word, last_word)
//
// An item is packed in the cycle it is accepted and its words go into the result buffer at
// the accepting edge. They move to the output register one word per cycle while the output
// is not stalled. An item yielding at most one word is taken every cycle while the output
// is not stalled. While the buffer holds more than one word of an item, the input stalls,
// because the result buffer drains through the single output register.
// Reset clears the partial word and fill position and sets the field width to 64 bits.
// A stall on the output holds the word in place and backs up into the buffer and the input.

module variable_width_word_packer_core import vwwp_pkg::*; #(
    parameter int WORD_BITS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [CFG_BITS-1:0] cfg_data,
    input  logic                coef_valid,
    output logic                coef_stall,
    input  coef_item_t          coef_item,
    output logic                word_valid,
    input  logic                word_stall,
    output word_item_t          word_item
);

    localparam int FW = $clog2(WORD_BITS);

    // Configuration and stream state.
    logic [CFG_BITS-1:0]     field_bits_reg;
    logic [WORD_BITS-1:0]    partial_reg;
    logic [WORD_BITS-1:0]    partial_next;
    logic [FW-1:0]           fill_reg;
    logic [FW-1:0]           fill_next;

    // Result buffer: the words of the most recent item, drained one per cycle unless the output stalls.
    logic [WORD_BITS-1:0]    buf_words_reg [MAX_RESULTS];
    logic [WORD_BITS-1:0]    pack_words    [MAX_RESULTS];
    logic [RESULT_CNT_W-1:0] buf_left_reg;
    logic [RESULT_CNT_W-1:0] buf_left_next;
    logic [1:0]              buf_idx_reg;
    logic [1:0]              buf_idx_next;
    logic                    buf_last_reg;
    pack_ctrl_t              pack_ctrl;

    // Output register.
    logic                    word_valid_reg;
    logic                    word_valid_next;
    word_item_t              word_item_reg;
    word_item_t              word_item_next;

    logic                    accept;
    logic                    out_load;
    logic                    emit;

    vwwp_pack #(
        .WORD_BITS (WORD_BITS)
    ) u_pack (
        .field_bits   (field_bits_reg),
        .partial      (partial_reg),
        .fill         (fill_reg),
        .item         (coef_item),
        .words        (pack_words),
        .ctrl         (pack_ctrl),
        .partial_next (partial_next),
        .fill_next    (fill_next)
    );

    // The output register can load when it is empty or its word is being taken.
    assign out_load = !word_valid_reg || !word_stall;
    assign emit     = (buf_left_reg != '0) && out_load;

    // A new item may enter once the buffer is empty or is handing over its final word.
    assign coef_stall = !((buf_left_reg == '0) ||
                          ((buf_left_reg == RESULT_CNT_W'(1)) && out_load));
    assign accept     = coef_valid && !coef_stall;

    always_comb
    begin
        buf_left_next   = buf_left_reg;
        buf_idx_next    = buf_idx_reg;
        word_valid_next = word_valid_reg;
        word_item_next  = word_item_reg;

        if (accept)
        begin
            buf_left_next = pack_ctrl.count;
            buf_idx_next  = '0;
        end
        else if (emit)
        begin
            buf_left_next = buf_left_reg - RESULT_CNT_W'(1);
            buf_idx_next  = buf_idx_reg + 2'd1;
        end

        if (emit)
        begin
            word_valid_next           = 1'b1;
            word_item_next.packed_word = COEFF_BITS'(buf_words_reg[buf_idx_reg]);
            word_item_next.last_word   = buf_last_reg && (buf_left_reg == RESULT_CNT_W'(1));
        end
        else if (out_load)
        begin
            word_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_bits_reg <= FIELD_BITS_RESET;
            partial_reg    <= '0;
            fill_reg       <= '0;
            buf_left_reg   <= '0;
            buf_idx_reg    <= '0;
            word_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                field_bits_reg <= cfg_data;
            end
            if (accept)
            begin
                partial_reg <= partial_next;
                fill_reg    <= fill_next;
            end
            buf_left_reg   <= buf_left_next;
            buf_idx_reg    <= buf_idx_next;
            word_valid_reg <= word_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            buf_words_reg <= pack_words;
            buf_last_reg  <= pack_ctrl.ends_stream;
        end
        word_item_reg <= word_item_next;
    end

    assign word_valid = word_valid_reg;
    assign word_item  = word_item_reg;

endmodule

// File: src/vwwp_pack.sv
// Combinational packing step: places one field behind the partial word.
`timescale 1ns / 1ps

module vwwp_pack import vwwp_pkg::*; #(
    parameter int WORD_BITS = 64
) (
    input  logic [CFG_BITS-1:0]          field_bits,
    input  logic [WORD_BITS-1:0]         partial,
    input  logic [$clog2(WORD_BITS)-1:0] fill,
    input  coef_item_t                   item,
    output logic [WORD_BITS-1:0]         words [MAX_RESULTS],
    output pack_ctrl_t                   ctrl,
    output logic [WORD_BITS-1:0]         partial_next,
    output logic [$clog2(WORD_BITS)-1:0] fill_next
);

    localparam int FW = $clog2(WORD_BITS);
    localparam int SW = MAX_RESULTS * WORD_BITS;
    localparam int TW = CFG_BITS + 1;
    localparam logic [CFG_BITS-1:0] FIELD_CAP = CFG_BITS'(3 * WORD_BITS - 1);
    localparam logic [TW-1:0] ONE_WORD    = TW'(WORD_BITS);
    localparam logic [TW-1:0] TWO_WORDS   = TW'(2 * WORD_BITS);
    localparam logic [TW-1:0] THREE_WORDS = TW'(3 * WORD_BITS);

    logic [CFG_BITS-1:0]   width;
    logic [COEFF_BITS-1:0] mask;
    logic [COEFF_BITS-1:0] coef_masked;
    logic [SW-1:0]         stream;
    logic [TW-1:0]         total;
    logic [TW-1:0]         rem;
    logic [1:0]            full_words;
    logic                  flush;

    always_comb
    begin
        // A zero width acts as one bit; widths beyond three words less one saturate.
        if (field_bits == '0)
        begin
            width = CFG_BITS'(1);
        end
        else if (field_bits > FIELD_CAP)
        begin
            width = FIELD_CAP;
        end
        else
        begin
            width = field_bits;
        end

        if (width >= CFG_BITS'(COEFF_BITS))
        begin
            mask = '1;
        end
        else
        begin
            mask = ~({COEFF_BITS{1'b1}} << width[5:0]);
        end
        coef_masked = item.coefficient & mask;

        // Field bits above the coefficient are zero, so the stream is just an OR.
        stream = SW'(partial) | (SW'(coef_masked) << fill);
        total  = TW'(fill) + TW'(width);

        priority if (total >= THREE_WORDS)
        begin
            full_words = 2'd3;
            rem        = total - THREE_WORDS;
        end
        else if (total >= TWO_WORDS)
        begin
            full_words = 2'd2;
            rem        = total - TWO_WORDS;
        end
        else if (total >= ONE_WORD)
        begin
            full_words = 2'd1;
            rem        = total - ONE_WORD;
        end
        else
        begin
            full_words = 2'd0;
            rem        = total;
        end

        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            words[k] = stream[k*WORD_BITS +: WORD_BITS];
        end

        // A last item flushes the leftover bits as one more, zero-padded word.
        flush            = item.last_coeff && (rem != '0);
        ctrl.count       = RESULT_CNT_W'(full_words) + RESULT_CNT_W'(flush);
        ctrl.ends_stream = item.last_coeff;

        if (item.last_coeff)
        begin
            partial_next = '0;
            fill_next    = '0;
        end
        else
        begin
            partial_next = words[full_words];
            fill_next    = rem[FW-1:0];
        end
    end

endmodule

// File: src/vwwp_checker.sv
// Port-level checker for the word packer, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vwwp_checker import vwwp_pkg::*; #(
    parameter int WORD_BITS = 64
) (
    input logic       clk,
    input logic       rst_n,
    input logic       coef_valid,
    input logic       coef_stall,
    input coef_item_t coef_item,
    input logic       word_valid,
    input logic       word_stall,
    input word_item_t word_item
);

    // A stalled word stays valid and unchanged.
    `AST_HOLDS(a_word_hold, word_valid && word_stall |=> word_valid && $stable(word_item), "stalled word changed")

    // The end of a stream always yields a valid word on the output.
    `AST_HOLDS(a_last_yields, coef_valid && !coef_stall && coef_item.last_coeff |=> ##1 word_valid, "no word after last item")

    // Bits above the word width are never set.
    `AST_NEVER(a_word_width, word_valid && ((word_item.packed_word >> WORD_BITS) != '0), "bits beyond word width")

endmodule

bind variable_width_word_packer_core vwwp_checker #(
    .WORD_BITS (WORD_BITS)
) u_vwwp_checker (.*);
